### rtl/dmwf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwf_pkg
// Shared types, widths and the line median function of the directional
// weighted median filter.
// ----------------------------------------------------------------------------
package dmwf_pkg;

  localparam int WINDOW     = 5;
  localparam int LINE_LEN   = (WINDOW < 1) ? 1 : ((WINDOW > 9) ? 9 : WINDOW);
  localparam int DIR_COUNT  = 4;
  localparam int DIST_SCALE = 1000;

  localparam int DW   = 18;          // scaled distance, up to 255001
  localparam int PW   = 2 * DW;      // pair product
  localparam int TW   = 54;          // product of three distances
  localparam int MPW  = TW + 8;      // median times weight
  localparam int DENW = TW + 2;      // sum of four weights
  localparam int NUMW = 64;          // sum of four weighted medians
  localparam int QW   = 8;

  localparam int WSTAGES = 5;        // register stages of the weight pipeline

  typedef struct packed {
    logic                      border;
    logic [7:0]                center;
    logic [DIR_COUNT-1:0][7:0] med;
  } med_t;

  typedef struct packed {
    logic            border;
    logic [7:0]      center;
    logic [NUMW-1:0] num;
    logic [DENW-1:0] den;
  } frac_t;

  // median of the centre plus the low neighbor bytes, odd-even transposition sort
  function automatic logic [7:0] line_median(logic [7:0] c, logic [31:0] packed_px);
    logic [7:0]  v [LINE_LEN];
    logic [63:0] ext;
    logic [7:0]  t;
    ext  = {32'b0, packed_px};
    v[0] = c;
    for (int i = 1; i < LINE_LEN; i++) begin
      v[i] = ext[8*(i-1) +: 8];
    end
    for (int p = 0; p < LINE_LEN; p++) begin
      for (int i = p % 2; i + 1 < LINE_LEN; i += 2) begin
        if (v[i] > v[i+1]) begin
          t      = v[i];
          v[i]   = v[i+1];
          v[i+1] = t;
        end
      end
    end
    return v[LINE_LEN/2];
  endfunction

endpackage

### rtl/dmwf_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwf_median
// One register stage: median of each of the four lines through the centre.
// ----------------------------------------------------------------------------
module dmwf_median (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        center_pixel,
  input  logic [31:0]       vertical_neighbors,
  input  logic [31:0]       horizontal_neighbors,
  input  logic [31:0]       main_diagonal_neighbors,
  input  logic [31:0]       anti_diagonal_neighbors,
  input  logic              at_border,
  output logic              out_valid,
  input  logic              out_ready,
  output dmwf_pkg::med_t    out_data
);
  import dmwf_pkg::*;

  logic en;
  med_t res;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    res.border = at_border;
    res.center = center_pixel;
    res.med[0] = line_median(center_pixel, vertical_neighbors);
    res.med[1] = line_median(center_pixel, horizontal_neighbors);
    res.med[2] = line_median(center_pixel, main_diagonal_neighbors);
    res.med[3] = line_median(center_pixel, anti_diagonal_neighbors);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      out_data <= res;
    end
  end

endmodule

### rtl/dmwf_weight.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwf_weight
// Five stages: distances, pair products, three-way products, weighted
// medians with weight sum, numerator sum.
// ----------------------------------------------------------------------------
module dmwf_weight (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dmwf_pkg::med_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dmwf_pkg::frac_t   out_data
);
  import dmwf_pkg::*;

  logic [WSTAGES-1:0] v;
  logic [WSTAGES-1:0] en;

  // stage 1
  logic [DIR_COUNT-1:0][DW-1:0] d1;
  med_t                         m1;
  // stage 2
  logic [DIR_COUNT-1:0][DW-1:0] d2;
  logic [PW-1:0]                d01, d23;
  med_t                         m2;
  // stage 3
  logic [DIR_COUNT-1:0][TW-1:0] p3;
  med_t                         m3;
  // stage 4
  logic [DIR_COUNT-1:0][MPW-1:0] mp4;
  logic [DENW-1:0]               den4;
  med_t                          m4;

  logic [DIR_COUNT-1:0][DW-1:0] d_calc;

  always_comb begin
    en[WSTAGES-1] = !v[WSTAGES-1] || out_ready;
    for (int k = WSTAGES - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end
  assign in_ready  = en[0];
  assign out_valid = v[WSTAGES-1];

  always_comb begin
    for (int i = 0; i < DIR_COUNT; i++) begin
      logic [7:0] diff;
      diff = (in_data.med[i] > in_data.center) ? in_data.med[i] - in_data.center
                                               : in_data.center - in_data.med[i];
      d_calc[i] = DW'(DW'(diff) * DW'(DIST_SCALE)) + DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < WSTAGES; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1 <= d_calc;
      m1 <= in_data;
    end
    if (en[1]) begin
      d2  <= d1;
      d01 <= d1[0] * d1[1];
      d23 <= d1[2] * d1[3];
      m2  <= m1;
    end
    if (en[2]) begin
      p3[0] <= TW'(d23 * d2[1]);
      p3[1] <= TW'(d23 * d2[0]);
      p3[2] <= TW'(d01 * d2[3]);
      p3[3] <= TW'(d01 * d2[2]);
      m3    <= m2;
    end
    if (en[3]) begin
      for (int i = 0; i < DIR_COUNT; i++) begin
        mp4[i] <= MPW'(m3.med[i]) * MPW'(p3[i]);
      end
      den4 <= DENW'(p3[0]) + DENW'(p3[1]) + DENW'(p3[2]) + DENW'(p3[3]);
      m4   <= m3;
    end
    if (en[4]) begin
      out_data.border <= m4.border;
      out_data.center <= m4.center;
      out_data.den    <= den4;
      out_data.num    <= NUMW'(mp4[0]) + NUMW'(mp4[1]) + NUMW'(mp4[2]) + NUMW'(mp4[3]);
    end
  end

  // every distance is at least one, so the weight sum is at least four
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    v[3] |-> den4 >= DENW'(4))
    else $error("weight sum below four");

  a_dist_odd: assert property (@(posedge clk) disable iff (rst)
    v[0] |-> (d1[0][0] && d1[1][0] && d1[2][0] && d1[3][0]))
    else $error("distance lost its offset");

endmodule

### rtl/dmwf_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwf_divider
// Restoring divider, one quotient bit per stage, eight stages; border items
// return the centre.
// ----------------------------------------------------------------------------
module dmwf_divider (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dmwf_pkg::frac_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        filtered_pixel
);
  import dmwf_pkg::*;

  logic [QW-1:0]             v;
  logic [QW-1:0]             en;
  logic [QW-1:0][NUMW-1:0]   rem;
  logic [QW-1:0][DENW-1:0]   den;
  logic [QW-1:0][QW-1:0]     quo;
  logic [QW-1:0]             border;
  logic [QW-1:0][7:0]        center;

  logic [QW-1:0][NUMW-1:0]   rem_in;
  logic [QW-1:0][DENW-1:0]   den_in;
  logic [QW-1:0][QW-1:0]     quo_in;
  logic [QW-1:0][NUMW-1:0]   rem_next;
  logic [QW-1:0][QW-1:0]     quo_next;

  always_comb begin
    en[QW-1] = !v[QW-1] || out_ready;
    for (int k = QW - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end
  assign in_ready  = en[0];
  assign out_valid = v[QW-1];

  always_comb begin
    rem_in[0] = in_data.num;
    den_in[0] = in_data.den;
    quo_in[0] = '0;
    for (int k = 1; k < QW; k++) begin
      rem_in[k] = rem[k-1];
      den_in[k] = den[k-1];
      quo_in[k] = quo[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      logic [NUMW-1:0] sh;
      sh          = NUMW'(den_in[k]) << (QW - 1 - k);
      rem_next[k] = rem_in[k];
      quo_next[k] = quo_in[k];
      if (rem_in[k] >= sh) begin
        rem_next[k]             = rem_in[k] - sh;
        quo_next[k][QW - 1 - k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < QW; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (en[k]) begin
        rem[k]    <= rem_next[k];
        den[k]    <= den_in[k];
        quo[k]    <= quo_next[k];
        border[k] <= (k == 0) ? in_data.border : border[(k == 0) ? 0 : k - 1];
        center[k] <= (k == 0) ? in_data.center : center[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign filtered_pixel = border[QW-1] ? center[QW-1] : quo[QW-1];

  // a weighted mean never exceeds the largest median, so the quotient fits
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (v[QW-1] && !border[QW-1]) |-> rem[QW-1] < NUMW'(den[QW-1]))
    else $error("remainder not below divisor");

  a_first_fits: assert property (@(posedge clk) disable iff (rst)
    (v[0] && !border[0] && den[0] != '0) |-> rem[0] < (NUMW'(den[0]) << (QW - 1)))
    else $error("quotient overflows eight bits");

endmodule

### rtl/directional_median_weighted_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directional_median_weighted_filter_top
// Directional weighted median of a 5x5 window: four line medians weighted by
// inverse distance to the centre.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, center_pixel, *_neighbors,  | sink
//          | at_border                                      |
//  out     | out_valid, out_ready, filtered_pixel           | source
//
//  one window per clock while the output is ready; stages: median 1, weights 5,
//  divider 8 (one quotient bit per stage)
//  every stage has its own valid bit and moves when the stage ahead is free,
//  so a stalled output only holds back stages that are full
//  synchronous reset clears the valid bits only
// ----------------------------------------------------------------------------
module directional_median_weighted_filter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  center_pixel,
  input  logic [31:0] vertical_neighbors,
  input  logic [31:0] horizontal_neighbors,
  input  logic [31:0] main_diagonal_neighbors,
  input  logic [31:0] anti_diagonal_neighbors,
  input  logic        at_border,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  filtered_pixel
);
  import dmwf_pkg::*;

  logic  med_valid, med_ready;
  med_t  med_data;
  logic  frac_valid, frac_ready;
  frac_t frac_data;

  dmwf_median u_median (
    .clk                     (clk),
    .rst                     (rst),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .center_pixel            (center_pixel),
    .vertical_neighbors      (vertical_neighbors),
    .horizontal_neighbors    (horizontal_neighbors),
    .main_diagonal_neighbors (main_diagonal_neighbors),
    .anti_diagonal_neighbors (anti_diagonal_neighbors),
    .at_border               (at_border),
    .out_valid               (med_valid),
    .out_ready               (med_ready),
    .out_data                (med_data)
  );

  dmwf_weight u_weight (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (med_valid),
    .in_ready  (med_ready),
    .in_data   (med_data),
    .out_valid (frac_valid),
    .out_ready (frac_ready),
    .out_data  (frac_data)
  );

  dmwf_divider u_divider (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (frac_valid),
    .in_ready       (frac_ready),
    .in_data        (frac_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_pixel (filtered_pixel)
  );

endmodule

### tb/sv/dmwf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwf_checker
// Watches both channels of the directional weighted median filter, predicts
// the filtered pixel of every window taken in and compares it with the
// pixels that come out, in order.
// ----------------------------------------------------------------------------
module dmwf_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  center_pixel,
  input  logic [31:0] vertical_neighbors,
  input  logic [31:0] horizontal_neighbors,
  input  logic [31:0] main_diagonal_neighbors,
  input  logic [31:0] anti_diagonal_neighbors,
  input  logic        at_border,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  filtered_pixel,
  output int          fail_count,
  output int          pending_count
);
  import dmwf_pkg::*;

  logic [7:0] pixel_queue [$];

  // insertion sort of the centre plus the low neighbor bytes
  function automatic logic [7:0] median_of_line(logic [7:0] c, logic [31:0] px);
    logic [7:0]  v [9];
    logic [63:0] ext;
    logic [7:0]  key;
    int          j;
    ext  = {32'b0, px};
    v[0] = c;
    for (int i = 1; i < LINE_LEN; i++) v[i] = ext[8*(i-1) +: 8];
    for (int i = 1; i < LINE_LEN; i++) begin
      key = v[i];
      j = i;
      while (j > 0 && v[j-1] > key) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = key;
    end
    return v[LINE_LEN/2];
  endfunction

  function automatic logic [7:0] weighted_pixel(logic [7:0] c, logic [31:0] lines [4],
                                                logic bord);
    logic [63:0] m [4];
    logic [63:0] d [4];
    logic [63:0] num, den, p;
    if (bord) return c;
    num = '0;
    den = '0;
    for (int i = 0; i < 4; i++) begin
      m[i] = 64'(median_of_line(c, lines[i]));
      d[i] = 64'(DIST_SCALE) * ((m[i] > 64'(c)) ? m[i] - 64'(c) : 64'(c) - m[i]) + 64'd1;
    end
    for (int i = 0; i < 4; i++) begin
      p = 64'd1;
      for (int j = 0; j < 4; j++) if (j != i) p = p * d[j];
      num += m[i] * p;
      den += p;
    end
    return 8'(num / den);
  endfunction

  assign pending_count = pixel_queue.size();

  always @(posedge clk) begin
    logic [31:0] lines [4];
    logic [7:0]  want;
    if (rst) begin
      fail_count <= 0;
      pixel_queue.delete();
    end else begin
      if (in_valid && in_ready) begin
        lines[0] = vertical_neighbors;
        lines[1] = horizontal_neighbors;
        lines[2] = main_diagonal_neighbors;
        lines[3] = anti_diagonal_neighbors;
        pixel_queue.insert(pixel_queue.size(), weighted_pixel(center_pixel, lines, at_border));
      end
      if (out_valid && out_ready) begin
        if (pixel_queue.size() == 0) begin
          $error("unexpected transfer: filtered_pixel %0d", filtered_pixel);
          fail_count <= fail_count + 1;
        end else begin
          want = pixel_queue.pop_front();
          if (filtered_pixel !== want) begin
            $error("filtered_pixel: expected %0d, actual %0d", want, filtered_pixel);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives windows into the directional weighted median filter with random
// gaps and output stalls, directed corner windows first, then random ones.
// ----------------------------------------------------------------------------
module testbench;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  center_pixel = '0;
  logic [31:0] vertical_neighbors = '0;
  logic [31:0] horizontal_neighbors = '0;
  logic [31:0] main_diagonal_neighbors = '0;
  logic [31:0] anti_diagonal_neighbors = '0;
  logic        at_border = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  filtered_pixel;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  bit          long_hold = 1'b0;

  localparam int CYCLE_LIMIT = 400000;

  always #5 clk = ~clk;

  directional_median_weighted_filter_top dut (.*);

  dmwf_checker checker_i (.*);

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // pixel near the centre so medians land close to it and weights differ
  function automatic logic [7:0] near_pixel(logic [7:0] c);
    int v;
    v = int'(c) + $urandom_range(0, 8) - 4;
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
  endfunction

  function automatic logic [31:0] random_line(logic [7:0] c);
    logic [31:0] w;
    case ($urandom_range(0, 3))
      0: w = $urandom;
      1: for (int b = 0; b < 4; b++) w[8*b +: 8] = near_pixel(c);
      2: w = {4{c}};
      default: for (int b = 0; b < 4; b++) w[8*b +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
    endcase
    return w;
  endfunction

  task automatic send_window(logic [7:0] c, logic [31:0] v, logic [31:0] h,
                             logic [31:0] md, logic [31:0] ad, logic bord);
    in_valid                <= 1'b1;
    center_pixel            <= c;
    vertical_neighbors      <= v;
    horizontal_neighbors    <= h;
    main_diagonal_neighbors <= md;
    anti_diagonal_neighbors <= ad;
    at_border               <= bord;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic [7:0] c;
    c = (($urandom_range(0, 9)) == 0) ? ($urandom_range(0, 1) ? 8'hff : 8'h00) : 8'($urandom);
    send_window(c, random_line(c), random_line(c), random_line(c), random_line(c),
                ($urandom_range(0, 9) == 0));
  endtask

  // wait until the checker holds no outstanding pixel
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // receiver stalls, with one long hold-off
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (120) @(posedge clk);
        long_hold = 1'b0;
      end
      n = gap_length();
      if (n > 0 && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed windows: extremes, border, all equal, crossing lines
    send_window(8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_window(8'hff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0);
    send_window(8'h00, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0);
    send_window(8'hff, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_window(8'h5a, 32'hffffffff, 32'h0, 32'h12345678, 32'h9abcdef0, 1'b1);
    send_window(8'hff, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
    send_window(8'h80, 32'h80808080, 32'h80808080, 32'h80808080, 32'h80808080, 1'b0);
    send_window(8'h80, 32'h00ff00ff, 32'hff00ff00, 32'h0000ffff, 32'hffff0000, 1'b0);
    send_window(8'h10, 32'h11121314, 32'h0f0e0d0c, 32'hf0f1f2f3, 32'h01020304, 1'b0);
    send_window(8'h7f, 32'h80818283, 32'h7e7d7c7b, 32'h7f7f7f7f, 32'hff000100, 1'b0);
    send_window(8'hff, 32'hfefefefe, 32'h00000000, 32'hfffffffe, 32'h01010101, 1'b0);
    send_window(8'h01, 32'h00000102, 32'h02010000, 32'hffffff00, 32'h000000ff, 1'b0);
    send_window(8'hc3, 32'haaaaaaaa, 32'h55555555, 32'hcccccccc, 32'h33333333, 1'b0);
    // sender waits for the pipe to drain
    drain();
    // fill up against a held output
    long_hold = 1'b1;
    for (int i = 0; i < 60; i++) send_random();
    for (int i = 0; i < 1400; i++) begin
      idle_gap(gap_length());
      send_random();
      if (i == 700) begin
        drain();
      end
    end
    drain();
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
